// File: rtl/hsp_pkg.sv
// Shared package for the five-point heat stencil step.
// Holds the sizes, register codes, window type and grid clamp used by every rtl file.
// Depends on nothing.
`timescale 1ns / 1ps

package hsp_pkg;

  localparam int MAX_GRID   = 128;
  localparam int MIN_GRID   = 3;
  localparam int IDX_W      = $clog2(MAX_GRID);
  localparam int N_W        = $clog2(MAX_GRID + 1);
  localparam int CNT_W      = $clog2(MAX_GRID + 2);

  localparam int WORD_W     = 32;
  localparam int GRID_W     = 8;
  localparam int COEF_W     = 23;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;

  localparam int DIFF_W      = WORD_W + 3;
  localparam int PROD_W      = DIFF_W + COEF_W + 1;
  localparam int ROUND_SHIFT = 24;
  localparam int Q_W         = PROD_W - ROUND_SHIFT;
  localparam int SUM_W       = Q_W + 1;

  localparam logic [GRID_W-1:0] GRID_RESET = 8'd128;
  localparam logic [COEF_W-1:0] COEF_RESET = 23'd142606;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE = 1'b0,
    REG_DIFF_COEF = 1'b1
  } hsp_reg_e;

  typedef struct packed {
    logic signed [WORD_W-1:0] above;
    logic signed [WORD_W-1:0] below;
    logic signed [WORD_W-1:0] left;
    logic signed [WORD_W-1:0] center;
    logic signed [WORD_W-1:0] right;
    logic                     border;
    logic                     frame_end;
  } hsp_win_t;

  function automatic logic [N_W-1:0] eff_grid(input logic [GRID_W-1:0] g);
    logic [N_W-1:0] n;
    if (int'(g) < MIN_GRID) begin
      n = N_W'(MIN_GRID);
    end else if (int'(g) > MAX_GRID) begin
      n = N_W'(MAX_GRID);
    end else begin
      n = N_W'(g);
    end
    return n;
  endfunction

endpackage

// File: rtl/heat_stencil_5point_step.sv
// Top level of the five-point heat stencil step: position tracking, line stores,
// window cells and the update pipeline. Uses hsp_pkg, hsp_lstore, hsp_cell and hsp_update.
//
//   port group   direction  handshake                   payload
//   in           request in in_valid_i / in_ready_o     sample_i, filler_i
//   out          request out out_valid_o / out_ready_i  updated_o, frame_end_o
//   cfg          write      cfg_we_i                    cfg_idx_i, cfg_data_i
//
// One request is taken per cycle while in_ready_o is high; a result passes the stage-one
// register and the a, b, c and o update registers, and results trail the input stream by
// grid size plus one requests. The line stores are memories with registered reads, and
// per-column valid flags make them read as zero after reset, so no clearing pass is needed.
// in_ready_o falls only when all five pipeline registers hold results not yet taken.
`timescale 1ns / 1ps

module heat_stencil_5point_step (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [hsp_pkg::WORD_W-1:0]     sample_i,
  input  logic                                  filler_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [hsp_pkg::WORD_W-1:0]     updated_o,
  output logic                                  frame_end_o,
  input  logic                                  cfg_we_i,
  input  logic [hsp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [hsp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import hsp_pkg::*;

  localparam int QW = N_W + 1;

  logic [GRID_W-1:0] grid_q;
  logic [COEF_W-1:0] coef_q;
  logic [IDX_W-1:0]  col_q, col_d;
  logic [IDX_W-1:0]  row_q, row_d;
  logic [CNT_W-1:0]  fc_q, fc_d;
  logic              s1_vld_q;
  logic              bor_q;
  logic              fe_q;

  logic [N_W-1:0]    n;
  logic [CNT_W-1:0]  win_len;
  logic [IDX_W-1:0]  c, r, cm1, qr, nm1;
  logic [QW-1:0]     qr_t;
  logic [N_W-1:0]    c_inc, r_inc;
  logic              col_wrap, row_wrap;
  logic              ignore, step, emit, s1_rdy, upd_rdy;
  logic              border, fend, grid_wr;
  logic signed [WORD_W-1:0] sample_w;
  logic signed [WORD_W-1:0] right_w, below_w, above_w, center_w, left_w;
  hsp_win_t          win;

  always_comb begin
    n        = eff_grid(grid_q);
    win_len  = CNT_W'(n) + 1'b1;
    c        = (N_W'(col_q) < n) ? col_q : '0;
    r        = (N_W'(row_q) < n) ? row_q : '0;
    nm1      = IDX_W'(n - 1'b1);
    cm1      = (c != '0) ? c - 1'b1 : nm1;
    qr_t     = QW'(r) + QW'(n) - ((c != '0) ? QW'(1) : QW'(2));
    qr       = (qr_t >= QW'(n)) ? IDX_W'(qr_t - QW'(n)) : IDX_W'(qr_t);
    border   = (qr == '0) || (qr == nm1) || (cm1 == '0) || (cm1 == nm1);
    fend     = (qr == nm1) && (cm1 == nm1);
    c_inc    = N_W'(c) + 1'b1;
    r_inc    = N_W'(r) + 1'b1;
    col_wrap = c_inc >= n;
    row_wrap = r_inc >= n;
    sample_w = filler_i ? '0 : sample_i;
  end

  assign grid_wr    = cfg_we_i && (hsp_reg_e'(cfg_idx_i) == REG_GRID_SIZE);
  assign s1_rdy     = !s1_vld_q || upd_rdy;
  assign in_ready_o = s1_rdy;
  assign ignore     = filler_i && (fc_q == '0);
  assign step       = in_valid_i && s1_rdy && !ignore;
  assign emit       = filler_i || (fc_q == win_len);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    fc_d  = fc_q;
    if (grid_wr) begin
      col_d = '0;
      row_d = '0;
      fc_d  = '0;
    end else if (step) begin
      if (col_wrap) begin
        col_d = '0;
        row_d = row_wrap ? '0 : IDX_W'(r_inc);
      end else begin
        col_d = IDX_W'(c_inc);
        row_d = r;
      end
      if (!filler_i) begin
        if (fc_q < win_len) begin
          fc_d = fc_q + 1'b1;
        end
      end else begin
        fc_d = fc_q - 1'b1;
        if (fc_q == CNT_W'(1)) begin
          col_d = '0;
          row_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q   <= GRID_RESET;
      coef_q   <= COEF_RESET;
      col_q    <= '0;
      row_q    <= '0;
      fc_q     <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (hsp_reg_e'(cfg_idx_i))
          REG_GRID_SIZE: grid_q <= cfg_data_i[GRID_W-1:0];
          REG_DIFF_COEF: coef_q <= cfg_data_i[COEF_W-1:0];
          default:       coef_q <= coef_q;
        endcase
      end
      col_q <= col_d;
      row_q <= row_d;
      fc_q  <= fc_d;
      if (s1_rdy) begin
        s1_vld_q <= step && emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      bor_q <= border;
      fe_q  <= fend;
    end
  end

  hsp_lstore u_lstore (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .col_i    (c),
    .colm1_i  (cm1),
    .sample_i (sample_w),
    .right_o  (right_w),
    .below_o  (below_w),
    .above_o  (above_w)
  );

  hsp_cell u_center (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step),
    .d_i    (right_w),
    .q_o    (center_w)
  );

  hsp_cell u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step),
    .d_i    (center_w),
    .q_o    (left_w)
  );

  always_comb begin
    win.above     = above_w;
    win.below     = below_w;
    win.left      = left_w;
    win.center    = center_w;
    win.right     = right_w;
    win.border    = bor_q;
    win.frame_end = fe_q;
  end

  hsp_update u_update (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s1_vld_q),
    .in_ready_o  (upd_rdy),
    .win_i       (win),
    .coef_i      (coef_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .updated_o   (updated_o),
    .frame_end_o (frame_end_o)
  );

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fc_q <= win_len)
    else $error("Fill count exceeds the window length.");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    N_W'(col_q) < n)
    else $error("Column position lies outside the grid.");

  a_idle_filler: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && filler_i && (fc_q == '0) && !cfg_we_i
    |=> $stable(fc_q) && $stable(col_q) && $stable(row_q))
    else $error("A filler with nothing pending changed the position state.");

  a_full_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && !filler_i && (fc_q == win_len) |=> s1_vld_q)
    else $error("A sample with a full window released no result.");

endmodule

// File: rtl/hsp_cell.sv
// One word cell of the horizontal window chain.
// Loads its neighbour's word on every accepted request that steps the window (en_i); uses hsp_pkg.
`timescale 1ns / 1ps

module hsp_cell (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic signed [hsp_pkg::WORD_W-1:0] d_i,
  output logic signed [hsp_pkg::WORD_W-1:0] q_o
);
  import hsp_pkg::*;

  logic signed [WORD_W-1:0] word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_q <= '0;
    end else if (en_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

// File: rtl/hsp_lstore.sv
// The two line stores: the row above and the middle row, one word per column.
// Registered reads, per-entry valid flags so that unwritten entries read as zero; uses hsp_pkg.
`timescale 1ns / 1ps

module hsp_lstore (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic [hsp_pkg::IDX_W-1:0]         col_i,
  input  logic [hsp_pkg::IDX_W-1:0]         colm1_i,
  input  logic signed [hsp_pkg::WORD_W-1:0] sample_i,
  output logic signed [hsp_pkg::WORD_W-1:0] right_o,
  output logic signed [hsp_pkg::WORD_W-1:0] below_o,
  output logic signed [hsp_pkg::WORD_W-1:0] above_o
);
  import hsp_pkg::*;

  logic [WORD_W-1:0]   mid_mem   [MAX_GRID];
  logic [WORD_W-1:0]   above_mem [MAX_GRID];
  logic [MAX_GRID-1:0] mid_vld_q;
  logic [MAX_GRID-1:0] abv_vld_q;
  logic [WORD_W-1:0]   right_q;
  logic [WORD_W-1:0]   below_q;
  logic [WORD_W-1:0]   above_q;

  // The word read from the middle row becomes the centre on the next request,
  // and that centre is what is written into the row above.
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      mid_mem[col_i]     <= sample_i;
      above_mem[colm1_i] <= right_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_vld_q <= '0;
      abv_vld_q <= '0;
    end else if (step_i) begin
      mid_vld_q[col_i]   <= 1'b1;
      abv_vld_q[colm1_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      right_q <= '0;
      below_q <= '0;
      above_q <= '0;
    end else if (step_i) begin
      right_q <= mid_vld_q[col_i]   ? mid_mem[col_i]     : '0;
      below_q <= mid_vld_q[colm1_i] ? mid_mem[colm1_i]   : '0;
      above_q <= abv_vld_q[colm1_i] ? above_mem[colm1_i] : '0;
    end
  end

  assign right_o = $signed(right_q);
  assign below_o = $signed(below_q);
  assign above_o = $signed(above_q);

endmodule

// File: rtl/hsp_update.sv
// Arithmetic pipeline: Laplacian, coefficient product, rounding, then saturation or border centre.
// Four registered stages with valid and ready between them; uses hsp_pkg.
`timescale 1ns / 1ps

module hsp_update (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  hsp_pkg::hsp_win_t                 win_i,
  input  logic [hsp_pkg::COEF_W-1:0]        coef_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [hsp_pkg::WORD_W-1:0] updated_o,
  output logic                              frame_end_o
);
  import hsp_pkg::*;

  logic                     a_vld_q, b_vld_q, c_vld_q, o_vld_q;
  logic                     a_rdy, b_rdy, c_rdy, o_rdy;

  logic signed [DIFF_W-1:0] a_diff_q;
  logic signed [WORD_W-1:0] a_cen_q, b_cen_q, c_cen_q;
  logic                     a_bor_q, b_bor_q, c_bor_q;
  logic                     a_fe_q, b_fe_q, c_fe_q;
  logic signed [PROD_W-1:0] b_prod_q;
  logic signed [Q_W-1:0]    c_step_q;
  logic signed [WORD_W-1:0] o_upd_q;
  logic                     o_fe_q;

  logic signed [DIFF_W-1:0] diff_d;
  logic signed [COEF_W:0]   coef_s;
  logic signed [PROD_W-1:0] prod_d;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SUM_W-1:0]  sum;
  logic signed [WORD_W-1:0] sat;

  assign o_rdy      = !o_vld_q || out_ready_i;
  assign c_rdy      = !c_vld_q || o_rdy;
  assign b_rdy      = !b_vld_q || c_rdy;
  assign a_rdy      = !a_vld_q || b_rdy;
  assign in_ready_o = a_rdy;

  always_comb begin
    diff_d = DIFF_W'(win_i.above) + DIFF_W'(win_i.below) + DIFF_W'(win_i.left)
           + DIFF_W'(win_i.right) - (DIFF_W'(win_i.center) <<< 2);
    coef_s = $signed({1'b0, coef_i});
    prod_d = a_diff_q * coef_s;
    rnd    = b_prod_q + (PROD_W'(1) <<< (ROUND_SHIFT - 1));
    sum    = SUM_W'(c_cen_q) + SUM_W'(c_step_q);
    if (sum[SUM_W-1:WORD_W-1] == '0 || sum[SUM_W-1:WORD_W-1] == '1) begin
      sat = sum[WORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      sat = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      sat = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      o_vld_q <= 1'b0;
    end else begin
      if (a_rdy) begin
        a_vld_q <= in_valid_i;
      end
      if (b_rdy) begin
        b_vld_q <= a_vld_q;
      end
      if (c_rdy) begin
        c_vld_q <= b_vld_q;
      end
      if (o_rdy) begin
        o_vld_q <= c_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && a_rdy) begin
      a_diff_q <= diff_d;
      a_cen_q  <= win_i.center;
      a_bor_q  <= win_i.border;
      a_fe_q   <= win_i.frame_end;
    end
    if (a_vld_q && b_rdy) begin
      b_prod_q <= prod_d;
      b_cen_q  <= a_cen_q;
      b_bor_q  <= a_bor_q;
      b_fe_q   <= a_fe_q;
    end
    if (b_vld_q && c_rdy) begin
      c_step_q <= $signed(rnd[PROD_W-1:ROUND_SHIFT]);
      c_cen_q  <= b_cen_q;
      c_bor_q  <= b_bor_q;
      c_fe_q   <= b_fe_q;
    end
    if (c_vld_q && o_rdy) begin
      o_upd_q <= c_bor_q ? c_cen_q : sat;
      o_fe_q  <= c_fe_q;
    end
  end

  assign out_valid_o = o_vld_q;
  assign updated_o   = o_upd_q;
  assign frame_end_o = o_fe_q;

endmodule

// File: tb/tb.sv
// Self-checking bench for heat_stencil_5point_step: directed table, then random frames.
// Results come from a behavioural stencil model in this file, or from the table where a row is typed.
// Depends on rtl/hsp_pkg.sv and rtl/heat_stencil_5point_step.sv.
`timescale 1ns / 1ps

module tb;
  import hsp_pkg::*;

  localparam int ITEMS_TOTAL = 1550;
  localparam int SETTLE      = 10;
  localparam logic signed [WORD_W-1:0] TOP  = 32'sh7fffffff;
  localparam logic signed [WORD_W-1:0] BOT  = 32'sh80000000;
  localparam logic signed [WORD_W-1:0] TIEC = 32'sh00200000;
  localparam logic signed [WORD_W-1:0] JUNK = 32'sh5a5aa5a5;

  typedef enum bit {ROW_REQ, ROW_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    hsp_reg_e                 reg_sel;
    logic [CFG_DATA_W-1:0]    reg_val;
    logic                     filler;
    logic signed [WORD_W-1:0] sample;
    logic                     typed;
    logic signed [WORD_W-1:0] want_value;
    logic                     want_last;
  } step_row_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic                     last;
  } heat_point_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic signed [WORD_W-1:0]    sample_i;
  logic                        filler_i;
  logic                        out_valid_o;
  logic                        out_ready_i = 1'b0;
  logic signed [WORD_W-1:0]    updated_o;
  logic                        frame_end_o;
  logic                        cfg_we_i;
  logic [CFG_IDX_W-1:0]        cfg_idx_i;
  logic [CFG_DATA_W-1:0]       cfg_data_i;

  heat_point_t                 due_points[$];
  int                          mismatch_count = 0;
  int                          items_done = 0;
  int                          stall_left = 0;
  bit                          send_quiet = 1'b0;
  bit                          take_quiet = 1'b0;

  logic signed [WORD_W-1:0]    above_line [MAX_GRID];
  logic signed [WORD_W-1:0]    mid_line [MAX_GRID];
  logic signed [WORD_W-1:0]    centre_q;
  logic signed [WORD_W-1:0]    left_q;
  int unsigned                 at_row;
  int unsigned                 at_col;
  int unsigned                 pending;
  logic [GRID_W-1:0]           grid_cfg;
  logic [COEF_W-1:0]           coef_cfg;

  step_row_t script [27] = '{
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b1, JUNK, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b1, JUNK, 1'b1, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_GRID_SIZE, 23'd2,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_WRITE, REG_DIFF_COEF, 23'h7fffff,  1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TIEC,   1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, 32'sd0, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, BOT,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b0, TOP,  1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b1, JUNK, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b1, JUNK, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b1, JUNK, 1'b0, 32'sd0, 1'b0},
    '{ROW_REQ,   REG_GRID_SIZE, 23'd0,       1'b1, JUNK, 1'b0, 32'sd0, 1'b0}
  };

  heat_stencil_5point_step uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .sample_i    (sample_i),
    .filler_i    (filler_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .updated_o   (updated_o),
    .frame_end_o (frame_end_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  function automatic int pick_gap(input bit quiet);
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 65) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end else if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned span_of(input logic [GRID_W-1:0] g);
    if (g < 3) begin
      return 3;
    end else if (g > MAX_GRID) begin
      return MAX_GRID;
    end
    return 32'(g);
  endfunction

  function automatic logic signed [WORD_W-1:0] relax(
    input logic signed [WORD_W-1:0] c,
    input logic signed [WORD_W-1:0] u,
    input logic signed [WORD_W-1:0] d,
    input logic signed [WORD_W-1:0] l,
    input logic signed [WORD_W-1:0] r
  );
    longint lap;
    longint acc;
    longint sum;
    lap = longint'(u) + longint'(d) + longint'(l) + longint'(r) - 4 * longint'(c);
    acc = lap * longint'(coef_cfg) + (longint'(1) <<< 23);
    sum = longint'(c) + (acc >>> 24);
    if (sum > 64'sd2147483647) begin
      return TOP;
    end else if (sum < -64'sd2147483648) begin
      return BOT;
    end
    return sum[WORD_W-1:0];
  endfunction

  function automatic void clear_model();
    for (int i = 0; i < MAX_GRID; i++) begin
      above_line[i] = '0;
      mid_line[i] = '0;
    end
    centre_q = '0;
    left_q = '0;
    at_row = 0;
    at_col = 0;
    pending = 0;
    grid_cfg = GRID_RESET;
    coef_cfg = COEF_RESET;
  endfunction

  function automatic void step_heat(
    input  bit                       filler,
    input  logic signed [WORD_W-1:0] s_in,
    output bit                       live,
    output bit                       emit,
    output heat_point_t              pt
  );
    int unsigned n;
    int unsigned c;
    int unsigned r;
    int unsigned cm1;
    int unsigned qr;
    logic signed [WORD_W-1:0] s;
    logic signed [WORD_W-1:0] right_v;
    n = span_of(grid_cfg);
    s = filler ? '0 : s_in;
    live = 1'b1;
    emit = 1'b0;
    pt = '0;
    if (filler && pending == 0) begin
      live = 1'b0;
      return;
    end
    emit = filler || (pending >= n + 1);
    c = (at_col < n) ? at_col : 0;
    r = (at_row < n) ? at_row : 0;
    cm1 = (c != 0) ? c - 1 : n - 1;
    qr = (r + n - ((c != 0) ? 1 : 2)) % n;
    right_v = mid_line[c];
    if (qr == 0 || qr == n - 1 || cm1 == 0 || cm1 == n - 1) begin
      pt.value = centre_q;
    end else begin
      pt.value = relax(centre_q, above_line[cm1], mid_line[cm1], left_q, right_v);
    end
    pt.last = (qr == n - 1) && (cm1 == n - 1);
    above_line[cm1] = centre_q;
    left_q = centre_q;
    centre_q = right_v;
    mid_line[c] = s;
    if (c + 1 >= n) begin
      at_col = 0;
      at_row = (r + 1 >= n) ? 0 : r + 1;
    end else begin
      at_col = c + 1;
      at_row = r;
    end
    if (!filler) begin
      if (pending < n + 1) begin
        pending++;
      end
    end else begin
      pending--;
      if (pending == 0) begin
        at_row = 0;
        at_col = 0;
      end
    end
  endfunction

  task automatic push_request(
    input bit                       filler,
    input logic signed [WORD_W-1:0] s,
    input bit                       typed,
    input logic signed [WORD_W-1:0] want_value,
    input bit                       want_last
  );
    int          gap;
    bit          live;
    bit          emit;
    heat_point_t pt;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    filler_i <= filler;
    sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    step_heat(filler, s, live, emit, pt);
    if (live) begin
      items_done++;
    end
    if (emit) begin
      if (typed) begin
        pt.value = want_value;
        pt.last = want_last;
      end
      due_points.push_back(pt);
    end
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (due_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input hsp_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    if (idx == REG_GRID_SIZE) begin
      grid_cfg = val[GRID_W-1:0];
      at_row = 0;
      at_col = 0;
      pending = 0;
    end else begin
      coef_cfg = val[COEF_W-1:0];
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic logic signed [WORD_W-1:0] any_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        return TOP;
      end
      1: begin
        return BOT;
      end
      2, 3, 4, 5: begin
        return $signed($urandom_range(0, 1 << 20)) - 32'sd524288;
      end
      default: begin
        return $urandom;
      end
    endcase
  endfunction

  task automatic run_phase();
    logic [GRID_W-1:0]     g;
    logic [COEF_W-1:0]     cf;
    logic [31:0]           hi;
    int unsigned           n;
    int                    total;
    int                    pick;
    wait_idle();
    pick = $urandom_range(0, 19);
    case (pick)
      0: begin
        g = GRID_W'($urandom_range(0, 2));
      end
      1: begin
        g = GRID_W'($urandom_range(129, 255));
      end
      2: begin
        g = GRID_W'(MAX_GRID);
      end
      3, 4, 5: begin
        g = GRID_W'($urandom_range(9, 16));
      end
      default: begin
        g = GRID_W'($urandom_range(3, 8));
      end
    endcase
    pick = $urandom_range(0, 7);
    case (pick)
      0: begin
        cf = '0;
      end
      1: begin
        cf = '1;
      end
      2: begin
        cf = 23'd4194304;
      end
      3: begin
        cf = COEF_RESET;
      end
      default: begin
        cf = COEF_W'($urandom);
      end
    endcase
    hi = $urandom;
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_DIFF_COEF, cf);
      write_reg(REG_GRID_SIZE, {hi[CFG_DATA_W-GRID_W-1:0], g});
    end else begin
      write_reg(REG_GRID_SIZE, {hi[CFG_DATA_W-GRID_W-1:0], g});
      write_reg(REG_DIFF_COEF, cf);
    end
    send_quiet = ($urandom_range(0, 4) == 0);
    take_quiet = ($urandom_range(0, 4) == 0);
    n = span_of(g);
    if (n > 16) begin
      total = $urandom_range(n + 2, 3 * n);
    end else begin
      total = $urandom_range(1, 3) * n * n;
      if ($urandom_range(0, 5) == 0) begin
        total = $urandom_range(1, total);
      end
    end
    for (int k = 0; k < total; k++) begin
      if ($urandom_range(0, 29) == 0) begin
        push_request(1'b1, $urandom, 1'b0, '0, 1'b0);
      end
      if ($urandom_range(0, 199) == 0) begin
        wait_drained();
      end
      push_request(1'b0, any_sample(), 1'b0, '0, 1'b0);
    end
    for (int k = 0; k < int'(n) + 1 + int'($urandom_range(0, 2)); k++) begin
      push_request(1'b1, $urandom, 1'b0, '0, 1'b0);
    end
  endtask

  always @(posedge clk_i) begin : take_results
    heat_point_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (due_points.size() == 0) begin
          note_mismatch($sformatf("result %h with nothing outstanding", updated_o));
        end else begin
          want = due_points.pop_front();
          if (updated_o !== want.value) begin
            note_mismatch($sformatf("updated %h, want %h", updated_o, want.value));
          end
          if (frame_end_o !== want.last) begin
            note_mismatch($sformatf("frame_end %b, want %b", frame_end_o, want.last));
          end
        end
      end
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        stall_left = pick_gap(take_quiet);
      end
    end
  end

  initial begin
    #15_000_000;
    $display("FAIL");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    sample_i = '0;
    filler_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    clear_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        wait_idle();
        write_reg(script[i].reg_sel, script[i].reg_val);
      end else begin
        push_request(script[i].filler, script[i].sample, script[i].typed,
                     script[i].want_value, script[i].want_last);
      end
    end
    while (items_done < ITEMS_TOTAL) begin
      run_phase();
    end
    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && due_points.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
